@@ hdl/hocl_pkg.sv @@
package hocl_pkg;

    localparam int QUEUE_DEPTH_DEF = 32;
    localparam int TICKET_BITS_DEF = 16;
    localparam int LIMIT_W = 6;
    localparam int SLACK_W = 16;
    localparam int TICKET_PORT_W = 16;
    localparam int TIMEOUT_W = 16;
    localparam int TIME_W = 32;
    localparam int PRIO_W = 2;
    localparam logic [SLACK_W-1:0] SLACK_RESET = 16'd100;

    typedef enum logic [0:0] {
        REG_LIMIT = 1'b0,
        REG_SLACK = 1'b1
    } reg_index_t;

    typedef enum logic [1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DONE    = 2'd1,
        ACT_TICK    = 2'd2,
        ACT_CLOSE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PRIO_BACK   = 2'd0,
        PRIO_FRONT  = 2'd1,
        PRIO_KEEP   = 2'd2,
        PRIO_IGNORE = 2'd3
    } prio_t;

    typedef enum logic [2:0] {
        KIND_QUEUED   = 3'd0,
        KIND_FULL     = 3'd1,
        KIND_REMOVED  = 3'd2,
        KIND_NOTFOUND = 3'd3,
        KIND_START    = 3'd4,
        KIND_TIMEOUT  = 3'd5,
        KIND_ABORT    = 3'd6,
        KIND_END      = 3'd7
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_PASS_RD,
        ST_PASS_EV,
        ST_PASS_END,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic                     valid;
        kind_t                    kind;
        logic [TICKET_PORT_W-1:0] tk;
        logic                     last;
    } push_t;

endpackage

@@ hdl/half_open_connection_limiter_top.sv @@
// Connection request queue with a limit on how many requests connect at once.
// Each word is one action (enqueue, done, tick or close) and yields one or
// more result words, the final one marked by last. An action is carried out
// step by step: the queue memory is read and written one entry at a time,
// for each entry touched by its compaction or shift pass and for each entry
// visited by the start walk, and an action takes longer while the result side
// stalls. The input is stalled for the whole action. No clearing pass is
// needed after reset.
module half_open_connection_limiter_top
    import hocl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic [PRIO_W-1:0]        priority_req,
    input  logic [TIMEOUT_W-1:0]     timeout_ticks,
    input  logic [TICKET_PORT_W-1:0] ticket,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [2:0]               kind,
    output logic [TICKET_PORT_W-1:0] ticket_out,
    output logic                     last,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [SLACK_W-1:0]       cfg_data
);

    logic [LIMIT_W-1:0]       limit_reg;
    logic [SLACK_W-1:0]       slack_reg;
    logic                     out_valid_reg;
    logic [2:0]               kind_reg;
    logic [TICKET_PORT_W-1:0] ticket_out_reg;
    logic                     last_reg;
    logic                     out_free;
    push_t                    push;

    assign out_free = !out_valid_reg || !out_stall;

    hocl_core #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TICKET_BITS (TICKET_BITS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .priority_req  (priority_req),
        .timeout_ticks (timeout_ticks),
        .ticket        (ticket),
        .limit         (limit_reg),
        .slack         (slack_reg),
        .out_free      (out_free),
        .push          (push)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= '0;
            slack_reg     <= SLACK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_index_t'(cfg_index))
                    REG_LIMIT: limit_reg <= cfg_data[LIMIT_W-1:0];
                    REG_SLACK: slack_reg <= cfg_data;
                    default:   slack_reg <= slack_reg;
                endcase
            end
            if (push.valid)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            kind_reg       <= push.kind;
            ticket_out_reg <= push.tk;
            last_reg       <= push.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = kind_reg;
    assign ticket_out = ticket_out_reg;
    assign last       = last_reg;

endmodule

@@ hdl/hocl_core.sv @@
module hocl_core
    import hocl_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TICKET_BITS = TICKET_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               action,
    input  logic [PRIO_W-1:0]        priority_req,
    input  logic [TIMEOUT_W-1:0]     timeout_ticks,
    input  logic [TICKET_PORT_W-1:0] ticket,
    input  logic [LIMIT_W-1:0]       limit,
    input  logic [SLACK_W-1:0]       slack,
    input  logic                     out_free,
    output push_t                    push
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int EW = TICKET_BITS + PRIO_W + 1 + TIMEOUT_W + TIME_W;
    localparam int EXP_LO = 0;
    localparam int TMO_LO = TIME_W;
    localparam int CONN_B = TIME_W + TIMEOUT_W;
    localparam int PRIO_LO = CONN_B + 1;
    localparam int TK_LO = PRIO_LO + PRIO_W;

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] rdata_reg;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [EW-1:0] mem_wd;
    logic          mem_re;
    logic [AW-1:0] mem_ra;

    state_t                   state_reg, state_next;
    action_t                  act_reg, act_next;
    logic [PRIO_W-1:0]        prio_reg, prio_next;
    logic [TIMEOUT_W-1:0]     tmo_reg, tmo_next;
    logic [TICKET_BITS-1:0]   tk_reg, tk_next;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [CW-1:0]            cc_reg, cc_next;
    logic [TICKET_BITS-1:0]   nt_reg, nt_next;
    logic [TIME_W-1:0]        now_reg, now_next;
    logic [TIME_W-1:0]        thr_reg, thr_next;
    logic [CW-1:0]            r_reg, r_next;
    logic [CW-1:0]            w_reg, w_next;
    logic                     found_reg, found_next;
    logic                     pend_valid_reg, pend_valid_next;
    kind_t                    pend_kind_reg, pend_kind_next;
    logic [TICKET_PORT_W-1:0] pend_tk_reg, pend_tk_next;

    logic                     emit_en;
    kind_t                    emit_kind;
    logic [TICKET_PORT_W-1:0] emit_tk;

    logic [TICKET_BITS-1:0] r_tk;
    logic [PRIO_W-1:0]      r_prio;
    logic                   r_conn;
    logic [TIMEOUT_W-1:0]   r_tmo;
    logic [TIME_W-1:0]      r_exp;
    logic [CW-1:0]          r_dec;
    logic                   can_push;
    logic                   full;
    logic                   limit_hit;
    logic                   at_end;
    logic                   drop;
    logic                   stall_pass;
    logic                   stall_walk;
    logic [EW-1:0]          new_entry;
    logic [EW-1:0]          start_entry;

    assign r_tk   = rdata_reg[TK_LO +: TICKET_BITS];
    assign r_prio = rdata_reg[PRIO_LO +: PRIO_W];
    assign r_conn = rdata_reg[CONN_B];
    assign r_tmo  = rdata_reg[TMO_LO +: TIMEOUT_W];
    assign r_exp  = rdata_reg[EXP_LO +: TIME_W];
    assign r_dec  = r_reg - CW'(1);

    assign can_push  = !pend_valid_reg || out_free;
    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign limit_hit = (limit != '0) && (CMPW'(cc_reg) >= CMPW'(limit));
    assign at_end    = (r_reg == cnt_reg);
    assign in_stall  = (state_reg != ST_IDLE);

    always_comb
    begin
        unique case (act_reg)
            ACT_DONE:  drop = !found_reg && (r_tk == tk_reg);
            ACT_TICK:  drop = r_conn && (r_exp < thr_reg);
            ACT_CLOSE: drop = (r_prio <= PRIO_W'(PRIO_FRONT));
            default:   drop = 1'b0;
        endcase
    end

    assign stall_pass = drop && (act_reg != ACT_DONE) && !can_push;
    assign stall_walk = !r_conn && !can_push;

    assign new_entry = {nt_reg, prio_reg, 1'b0, tmo_reg, TIME_W'(0)};
    assign start_entry = {r_tk, r_prio, 1'b1, r_tmo, now_reg + TIME_W'(r_tmo)};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_ra];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                unique case (act_reg)
                    ACT_ENQUEUE:
                    begin
                        priority if (prio_reg == PRIO_W'(PRIO_IGNORE))
                        begin
                            state_next = ST_FINISH;
                        end
                        else if (full)
                        begin
                            if (can_push)
                            begin
                                state_next = ST_FINISH;
                            end
                        end
                        else if (prio_reg == PRIO_W'(PRIO_BACK))
                        begin
                            if (can_push)
                            begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        else if (cnt_reg == '0)
                        begin
                            state_next = ST_INSERT;
                        end
                        else
                        begin
                            state_next = ST_SHIFT_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_PASS_RD;
                    end
                endcase
            end
            ST_SHIFT_RD:
            begin
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                state_next = (r_reg == CW'(1)) ? ST_INSERT : ST_SHIFT_RD;
            end
            ST_INSERT:
            begin
                if (can_push)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_PASS_RD:
            begin
                state_next = at_end ? ST_PASS_END : ST_PASS_EV;
            end
            ST_PASS_EV:
            begin
                if (!stall_pass)
                begin
                    state_next = ST_PASS_RD;
                end
            end
            ST_PASS_END:
            begin
                unique case (act_reg)
                    ACT_DONE:
                    begin
                        if (can_push)
                        begin
                            state_next = found_reg ? ST_WALK_RD : ST_FINISH;
                        end
                    end
                    ACT_TICK:
                    begin
                        state_next = ST_WALK_RD;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_WALK_RD:
            begin
                state_next = (at_end || limit_hit) ? ST_FINISH : ST_WALK_EV;
            end
            ST_WALK_EV:
            begin
                if (!stall_walk)
                begin
                    state_next = ST_WALK_RD;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        act_next   = act_reg;
        prio_next  = prio_reg;
        tmo_next   = tmo_reg;
        tk_next    = tk_reg;
        cnt_next   = cnt_reg;
        cc_next    = cc_reg;
        nt_next    = nt_reg;
        now_next   = now_reg;
        thr_next   = thr_reg;
        r_next     = r_reg;
        w_next     = w_reg;
        found_next = found_reg;
        mem_we     = 1'b0;
        mem_wa     = r_reg[AW-1:0];
        mem_wd     = rdata_reg;
        mem_re     = 1'b0;
        mem_ra     = r_reg[AW-1:0];
        emit_en    = 1'b0;
        emit_kind  = KIND_END;
        emit_tk    = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    act_next  = action_t'(action);
                    prio_next = priority_req;
                    tmo_next  = timeout_ticks;
                    tk_next   = TICKET_BITS'(ticket);
                end
            end
            ST_DISPATCH:
            begin
                r_next     = '0;
                w_next     = '0;
                found_next = 1'b0;
                unique case (act_reg)
                    ACT_ENQUEUE:
                    begin
                        priority if (prio_reg == PRIO_W'(PRIO_IGNORE))
                        begin
                            r_next = '0;
                        end
                        else if (full)
                        begin
                            if (can_push)
                            begin
                                emit_en   = 1'b1;
                                emit_kind = KIND_FULL;
                            end
                        end
                        else if (prio_reg == PRIO_W'(PRIO_BACK))
                        begin
                            if (can_push)
                            begin
                                mem_we    = 1'b1;
                                mem_wa    = cnt_reg[AW-1:0];
                                mem_wd    = new_entry;
                                emit_en   = 1'b1;
                                emit_kind = KIND_QUEUED;
                                emit_tk   = TICKET_PORT_W'(nt_reg);
                                cnt_next  = cnt_reg + CW'(1);
                                nt_next   = nt_reg + TICKET_BITS'(1);
                            end
                        end
                        else
                        begin
                            r_next = cnt_reg;
                        end
                    end
                    ACT_TICK:
                    begin
                        now_next = now_reg + TIME_W'(1);
                        thr_next = now_reg + TIME_W'(1) + TIME_W'(slack);
                    end
                    ACT_CLOSE:
                    begin
                        cc_next = '0;
                    end
                    default:
                    begin
                        found_next = 1'b0;
                    end
                endcase
            end
            ST_SHIFT_RD:
            begin
                mem_re = 1'b1;
                mem_ra = r_dec[AW-1:0];
            end
            ST_SHIFT_WR:
            begin
                mem_we = 1'b1;
                mem_wa = r_reg[AW-1:0];
                mem_wd = rdata_reg;
                r_next = r_reg - CW'(1);
            end
            ST_INSERT:
            begin
                if (can_push)
                begin
                    mem_we    = 1'b1;
                    mem_wa    = '0;
                    mem_wd    = new_entry;
                    emit_en   = 1'b1;
                    emit_kind = KIND_QUEUED;
                    emit_tk   = TICKET_PORT_W'(nt_reg);
                    cnt_next  = cnt_reg + CW'(1);
                    nt_next   = nt_reg + TICKET_BITS'(1);
                    r_next    = '0;
                end
            end
            ST_PASS_RD:
            begin
                mem_re = !at_end;
            end
            ST_PASS_EV:
            begin
                if (!stall_pass)
                begin
                    r_next = r_reg + CW'(1);
                    if (drop)
                    begin
                        unique case (act_reg)
                            ACT_DONE:
                            begin
                                found_next = 1'b1;
                                if (r_conn && cc_reg != '0)
                                begin
                                    cc_next = cc_reg - CW'(1);
                                end
                            end
                            ACT_TICK:
                            begin
                                emit_en   = 1'b1;
                                emit_kind = KIND_TIMEOUT;
                                emit_tk   = TICKET_PORT_W'(r_tk);
                                if (cc_reg != '0)
                                begin
                                    cc_next = cc_reg - CW'(1);
                                end
                            end
                            default:
                            begin
                                emit_en   = 1'b1;
                                emit_kind = KIND_ABORT;
                                emit_tk   = TICKET_PORT_W'(r_tk);
                            end
                        endcase
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        mem_wa = w_reg[AW-1:0];
                        mem_wd = rdata_reg;
                        w_next = w_reg + CW'(1);
                        if (act_reg == ACT_CLOSE && r_conn)
                        begin
                            cc_next = cc_reg + CW'(1);
                        end
                    end
                end
            end
            ST_PASS_END:
            begin
                cnt_next = w_reg;
                r_next   = '0;
                if (act_reg == ACT_DONE && can_push)
                begin
                    emit_en   = 1'b1;
                    emit_kind = found_reg ? KIND_REMOVED : KIND_NOTFOUND;
                    emit_tk   = TICKET_PORT_W'(tk_reg);
                end
            end
            ST_WALK_RD:
            begin
                mem_re = !(at_end || limit_hit);
            end
            ST_WALK_EV:
            begin
                if (r_conn)
                begin
                    r_next = r_reg + CW'(1);
                end
                else if (can_push)
                begin
                    mem_we    = 1'b1;
                    mem_wa    = r_reg[AW-1:0];
                    mem_wd    = start_entry;
                    cc_next   = cc_reg + CW'(1);
                    emit_en   = 1'b1;
                    emit_kind = KIND_START;
                    emit_tk   = TICKET_PORT_W'(r_tk);
                    r_next    = r_reg + CW'(1);
                end
            end
            default:
            begin
                r_next = r_reg;
            end
        endcase
    end

    always_comb
    begin
        push            = '0;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_tk_next    = pend_tk_reg;
        if (emit_en)
        begin
            push.valid      = pend_valid_reg;
            push.kind       = pend_kind_reg;
            push.tk         = pend_tk_reg;
            pend_valid_next = 1'b1;
            pend_kind_next  = emit_kind;
            pend_tk_next    = emit_tk;
        end
        else if (state_reg == ST_FINISH && out_free)
        begin
            push.valid      = 1'b1;
            push.kind       = pend_valid_reg ? pend_kind_reg : KIND_END;
            push.tk         = pend_valid_reg ? pend_tk_reg : '0;
            push.last       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            cc_reg         <= '0;
            nt_reg         <= '0;
            now_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            cc_reg         <= cc_next;
            nt_reg         <= nt_next;
            now_reg        <= now_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        prio_reg      <= prio_next;
        tmo_reg       <= tmo_next;
        tk_reg        <= tk_next;
        thr_reg       <= thr_next;
        r_reg         <= r_next;
        w_reg         <= w_next;
        found_reg     <= found_next;
        pend_kind_reg <= pend_kind_next;
        pend_tk_reg   <= pend_tk_next;
    end

endmodule

@@ tb/tb_limiter_checker.sv @@
module tb_limiter_checker
    import hocl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               action,
    input  logic [PRIO_W-1:0]        priority_req,
    input  logic [TIMEOUT_W-1:0]     timeout_ticks,
    input  logic [TICKET_PORT_W-1:0] ticket,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [2:0]               kind,
    input  logic [TICKET_PORT_W-1:0] ticket_out,
    input  logic                     last,
    input  logic                     cfg_we,
    input  logic [0:0]               cfg_index,
    input  logic [SLACK_W-1:0]       cfg_data,
    output int                       fail_count,
    output int                       pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    typedef struct packed {
        kind_t                    kind;
        logic [TICKET_PORT_W-1:0] tk;
        logic                     last;
    } event_t;

    typedef struct {
        logic [15:0] tk;
        logic [1:0]  prio;
        logic        busy;
        logic [15:0] tmo;
        logic [31:0] exp;
    } slot_t;

    slot_t       q[$];
    int          n_busy;
    logic [15:0] tk_next;
    logic [31:0] now_t;
    logic [5:0]  lim;
    logic [15:0] slack;
    event_t      events_due[$];
    int          fails;

    assign fail_count = fails;
    assign pending = events_due.size();

    task automatic report(input string msg);
        $display("ERROR %0t: %s", $time, msg);
        fails++;
    endtask

    task automatic push_event(input kind_t k, input logic [15:0] t, inout int n);
        event_t e;
        e.kind = k;
        e.tk = t;
        e.last = 1'b0;
        events_due.insert(events_due.size(), e);
        n++;
    endtask

    task automatic start_idle(inout int n);
        for (int i = 0; i < q.size(); i++)
        begin
            if (lim != 0 && n_busy >= lim)
                break;
            if (!q[i].busy)
            begin
                q[i].busy = 1'b1;
                n_busy++;
                q[i].exp = now_t + 32'(q[i].tmo);
                push_event(KIND_START, q[i].tk, n);
            end
        end
    endtask

    task automatic apply_action(input action_t act, input logic [1:0] pr,
                                input logic [15:0] tmo, input logic [15:0] tk);
        int    n;
        int    k;
        bit    hit;
        slot_t s;
        logic [31:0] thr;
        event_t e;
        slot_t kept[$];
        n = 0;
        case (act)
            ACT_ENQUEUE:
            begin
                if (pr != PRIO_IGNORE)
                begin
                    if (q.size() >= DEPTH)
                        push_event(KIND_FULL, 16'd0, n);
                    else
                    begin
                        s.tk = tk_next;
                        s.prio = pr;
                        s.busy = 1'b0;
                        s.tmo = tmo;
                        s.exp = '0;
                        if (pr == PRIO_BACK)
                            q.insert(q.size(), s);
                        else
                            q.insert(0, s);
                        push_event(KIND_QUEUED, tk_next, n);
                        tk_next++;
                        start_idle(n);
                    end
                end
            end
            ACT_DONE:
            begin
                hit = 0;
                for (k = 0; k < q.size(); k++)
                    if (q[k].tk == tk)
                    begin
                        hit = 1;
                        break;
                    end
                if (hit)
                begin
                    if (q[k].busy && n_busy > 0)
                        n_busy--;
                    q.delete(k);
                    push_event(KIND_REMOVED, tk, n);
                    start_idle(n);
                end
                else
                    push_event(KIND_NOTFOUND, tk, n);
            end
            ACT_TICK:
            begin
                now_t++;
                thr = now_t + 32'(slack);
                k = 0;
                while (k < q.size())
                begin
                    if (q[k].busy && q[k].exp < thr)
                    begin
                        push_event(KIND_TIMEOUT, q[k].tk, n);
                        if (n_busy > 0)
                            n_busy--;
                        q.delete(k);
                    end
                    else
                        k++;
                end
                start_idle(n);
            end
            default:
            begin
                n_busy = 0;
                foreach (q[i])
                begin
                    if (q[i].prio > 2'd1)
                    begin
                        if (q[i].busy)
                            n_busy++;
                        kept.insert(kept.size(), q[i]);
                    end
                    else
                        push_event(KIND_ABORT, q[i].tk, n);
                end
                q = kept;
            end
        endcase
        if (n == 0)
            push_event(KIND_END, 16'd0, n);
        e = events_due[$];
        e.last = 1'b1;
        events_due[$] = e;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        event_t e;
        if (!rst_n)
        begin
            q.delete();
            events_due.delete();
            n_busy = 0;
            tk_next = '0;
            now_t = '0;
            lim = '0;
            slack = SLACK_RESET;
            fails = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_LIMIT)
                    lim = cfg_data[5:0];
                else
                    slack = cfg_data;
            end
            if (in_valid && !in_stall)
                apply_action(action_t'(action), priority_req, timeout_ticks, ticket);
            if (out_valid && !out_stall)
            begin
                if (events_due.size() == 0)
                    report($sformatf("unexpected word kind=%0d ticket=%0d", kind, ticket_out));
                else
                begin
                    e = events_due[0];
                    events_due.delete(0);
                    if (kind !== e.kind)
                        report($sformatf("kind %0d, expected %0d", kind, e.kind));
                    if (ticket_out !== e.tk)
                        report($sformatf("ticket %0d, expected %0d", ticket_out, e.tk));
                    if (last !== e.last)
                        report($sformatf("last %0b, expected %0b", last, e.last));
                end
            end
        end
    end
endmodule

@@ tb/tb_top.sv @@
module tb_top;
    import hocl_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam int LONG_HOLD_CYCLES = 300;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_stall;
    logic [1:0]               action = ACT_TICK;
    logic [PRIO_W-1:0]        priority_req = '0;
    logic [TIMEOUT_W-1:0]     timeout_ticks = '0;
    logic [TICKET_PORT_W-1:0] ticket = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [2:0]               kind;
    logic [TICKET_PORT_W-1:0] ticket_out;
    logic                     last;
    logic                     cfg_we = 1'b0;
    logic [0:0]               cfg_index = REG_LIMIT;
    logic [SLACK_W-1:0]       cfg_data = '0;
    int                       fail_count;
    int                       pending;
    int                       idle_cycles = 0;
    bit                       long_hold = 0;
    int                       hold_count = 0;
    int                       stall_mode = 0;

    always #4 clk = ~clk;

    half_open_connection_limiter_top dut (.*);

    tb_limiter_checker chk (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("half_open_connection_limiter_top test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (long_hold && hold_count < LONG_HOLD_CYCLES)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 1) == 0);
        if ($urandom_range(0, 60) == 0)
            stall_mode <= $urandom_range(0, 2);
    end

    task automatic send_word(input logic [1:0] act, input logic [1:0] pr,
                             input logic [15:0] tmo, input logic [15:0] tk);
        in_valid <= 1'b1;
        action <= act;
        priority_req <= pr;
        timeout_ticks <= tmo;
        ticket <= tk;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic gap();
        if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (150)
            @(posedge clk);
    endtask

    task automatic set_reg(input reg_index_t idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word(input int tix);
        int r;
        logic [15:0] tmo;
        r = $urandom_range(0, 99);
        tmo = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        if (r < 50)
            send_word(ACT_ENQUEUE, 2'($urandom_range(0, 3)), tmo, 16'($urandom));
        else if (r < 70)
            send_word(ACT_DONE, 2'($urandom_range(0, 3)), tmo,
                      ($urandom_range(0, 5) == 0) ? 16'($urandom)
                                                  : 16'(tix - $urandom_range(0, 20)));
        else if (r < 95)
            send_word(ACT_TICK, 2'($urandom_range(0, 3)), tmo, 16'($urandom));
        else
            send_word(ACT_CLOSE, 2'($urandom_range(0, 3)), tmo, 16'($urandom));
    endtask

    initial
    begin
        int tix;
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(ACT_TICK, 2'd0, 16'd0, 16'd0);
        send_word(ACT_DONE, 2'd0, 16'd0, 16'hFFFF);
        send_word(ACT_ENQUEUE, PRIO_BACK, 16'hFFFF, 16'hFFFF);
        send_word(ACT_ENQUEUE, PRIO_FRONT, 16'd0, 16'd0);
        send_word(ACT_ENQUEUE, PRIO_KEEP, 16'd500, 16'd0);
        send_word(ACT_ENQUEUE, PRIO_IGNORE, 16'd5, 16'd0);
        send_word(ACT_DONE, 2'd3, 16'd0, 16'd1);
        send_word(ACT_TICK, 2'd0, 16'd0, 16'd0);
        send_word(ACT_CLOSE, 2'd0, 16'd0, 16'd0);
        send_word(ACT_CLOSE, 2'd0, 16'd0, 16'd0);
        drain();
        set_reg(REG_LIMIT, 16'd2);
        set_reg(REG_SLACK, 16'd0);
        for (int i = 0; i < 34; i++)
            send_word(ACT_ENQUEUE, 2'(i % 3), 16'hFFFF, 16'd0);
        send_word(ACT_CLOSE, 2'd0, 16'd0, 16'd0);
        send_word(ACT_TICK, 2'd0, 16'd0, 16'd0);
        drain();

        tix = 40;
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: begin set_reg(REG_LIMIT, 16'd1); set_reg(REG_SLACK, 16'd5); end
                1: begin set_reg(REG_LIMIT, 16'd32); set_reg(REG_SLACK, 16'hFFFF); end
                2: begin set_reg(REG_LIMIT, 16'd63); set_reg(REG_SLACK, 16'd100); end
                3: begin set_reg(REG_LIMIT, 16'd0); set_reg(REG_SLACK, 16'd20); end
                default: begin set_reg(REG_LIMIT, 16'd3); set_reg(REG_SLACK, 16'd2); end
            endcase
            if (ph == 2)
                long_hold <= 1'b1;
            for (int i = 0; i < 32; i++)
            begin
                random_word(tix);
                tix++;
                gap();
            end
            drain();
        end

        if (fail_count == 0)
            $display("half_open_connection_limiter_top test passed");
        else
            $display("half_open_connection_limiter_top test failed");
        $finish;
    end
endmodule
